FILE: rtl/afs_pkg.sv
// afs_pkg: types, widths and codes shared by the animation frame selector
// no dependencies; imported by afs_ctrl, afs_datapath and animation_frame_selector
`timescale 1ns / 1ps
`default_nettype none

package afs_pkg;

    localparam int MAX_FRAMES    = 64;
    localparam int DELAY_BITS    = 32;
    localparam int FRAME_W       = $clog2(MAX_FRAMES);
    localparam int CNT_W         = $clog2(MAX_FRAMES + 1);
    localparam int POS_W         = 38;
    localparam int FRAME_COUNT_W = 7;
    localparam int APB_DATA_W    = 32;
    localparam int APB_ADDR_W    = 3;

    localparam logic [1:0] CMD_WRITE_DELAY = 2'd0;
    localparam logic [1:0] CMD_ADVANCE     = 2'd1;
    localparam logic [1:0] CMD_REWIND      = 2'd2;
    localparam logic [1:0] CMD_PLAY        = 2'd3;

    localparam logic REG_FRAME_COUNT = 1'b0;
    localparam logic REG_LOOP_ENABLE = 1'b1;

    typedef struct packed {
        logic [1:0]  command;
        logic [5:0]  frame_slot;
        logic [31:0] frame_delay_ns;
        logic [31:0] elapsed_ns;
    } afs_in_t;

    typedef struct packed {
        logic [5:0] current_frame;
        logic       is_playing;
        logic       frame_changed;
    } afs_out_t;

    typedef struct packed {
        logic               load;
        logic               sum_clr;
        logic               sum_step;
        logic               walk_clr;
        logic               rd_en;
        logic [FRAME_W-1:0] rd_addr;
        logic               zero_frame;
        logic               stop;
        logic               div_init;
        logic               div_step;
        logic               div_last;
        logic               search_step;
        logic               search_fail;
        logic               finish;
    } afs_cmd_t;

    typedef struct packed {
        logic total_zero;
        logic pos_ge;
        logic hit;
    } afs_stat_t;

endpackage

`default_nettype wire

FILE: rtl/afs_ctrl.sv
// afs_ctrl: sequencer for one item (apply, sum walk, decide, wrap, search, deliver)
// depends on afs_pkg; drives afs_datapath through afs_cmd_t
`timescale 1ns / 1ps
`default_nettype none

module afs_ctrl
    import afs_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    output logic                  result_valid,
    input  wire logic             result_stall,
    input  wire logic [CNT_W-1:0] frames_used,
    input  wire logic             loop_enable,
    input  wire afs_stat_t        status,
    output afs_cmd_t              cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_DECIDE,
        S_DIV,
        S_SEARCH,
        S_FINISH
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             result_valid_reg, result_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cnt_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_comb
    begin
        cmd               = '0;
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        result_valid_next = result_valid_reg && result_stall;
        cmd.rd_addr       = cnt_reg[FRAME_W-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load     = 1'b1;
                    cmd.sum_clr  = 1'b1;
                    cmd.walk_clr = 1'b1;
                    cnt_next     = '0;
                    state_next   = S_SUM;
                end
            end
            S_SUM:
            begin
                cmd.rd_en    = (cnt_reg < frames_used);
                cmd.sum_step = 1'b1;
                if (cnt_reg == frames_used)
                    state_next = S_DECIDE;
                else
                    cnt_next = cnt_reg + CNT_W'(1);
            end
            S_DECIDE:
            begin
                cnt_next = '0;
                if (status.total_zero)
                begin
                    cmd.zero_frame = 1'b1;
                    state_next     = S_FINISH;
                end
                else if (!loop_enable && status.pos_ge)
                begin
                    cmd.stop   = 1'b1;
                    state_next = S_FINISH;
                end
                else if (status.pos_ge)
                begin
                    cmd.div_init = 1'b1;
                    state_next   = S_DIV;
                end
                else
                begin
                    cmd.walk_clr = 1'b1;
                    state_next   = S_SEARCH;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_W'(POS_W - 1))
                begin
                    cmd.div_last = 1'b1;
                    cmd.walk_clr = 1'b1;
                    cnt_next     = '0;
                    state_next   = S_SEARCH;
                end
                else
                    cnt_next = cnt_reg + CNT_W'(1);
            end
            S_SEARCH:
            begin
                cmd.rd_en       = (cnt_reg < frames_used);
                cmd.search_step = 1'b1;
                if (status.hit)
                    state_next = S_FINISH;
                else if (cnt_reg == frames_used)
                begin
                    cmd.search_fail = 1'b1;
                    state_next      = S_FINISH;
                end
                else
                    cnt_next = cnt_reg + CNT_W'(1);
            end
            S_FINISH:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    cmd.finish        = 1'b1;
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;

endmodule

`default_nettype wire

FILE: rtl/afs_datapath.sv
// afs_datapath: delay memory, total, position, remainder unit, frame search and result word
// depends on afs_pkg; commanded by afs_ctrl
`timescale 1ns / 1ps
`default_nettype none

module afs_datapath
    import afs_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire afs_in_t          item,
    input  wire afs_cmd_t         cmd,
    input  wire logic [CNT_W-1:0] frames_used,
    output afs_stat_t             status,
    output afs_out_t              result
);

    logic [DELAY_BITS-1:0] delay_mem [MAX_FRAMES];
    logic [DELAY_BITS-1:0] rd_data_reg;
    logic [FRAME_W-1:0]    rd_idx_reg;
    logic                  rd_valid_reg;

    logic [POS_W-1:0]   total_reg, total_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               playing_reg, playing_next;
    logic [FRAME_W-1:0] shown_reg, shown_next;

    logic [POS_W-1:0]   cum_reg;
    logic [POS_W-1:0]   rem_reg;
    logic [POS_W-1:0]   dvd_reg;
    logic [FRAME_W-1:0] frame_reg;
    logic [FRAME_W-1:0] before_reg;
    afs_out_t           result_reg;

    logic [POS_W:0]     pos_sum;
    logic [POS_W:0]     cum_sum;
    logic [POS_W:0]     rem_shift;
    logic [POS_W:0]     rem_sub;
    logic [POS_W-1:0]   rem_new;
    logic [FRAME_W-1:0] last_frame;

    // delay memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.load && item.command == CMD_WRITE_DELAY)
            delay_mem[item.frame_slot] <= item.frame_delay_ns;
        if (cmd.rd_en)
        begin
            rd_data_reg <= delay_mem[cmd.rd_addr];
            rd_idx_reg  <= cmd.rd_addr;
        end
    end

    assign pos_sum    = {1'b0, pos_reg} + (POS_W + 1)'(item.elapsed_ns);
    assign cum_sum    = {1'b0, cum_reg} + (POS_W + 1)'(rd_data_reg);
    assign rem_shift  = {rem_reg, dvd_reg[POS_W-1]};
    assign rem_sub    = rem_shift - {1'b0, total_reg};
    assign rem_new    = (rem_shift >= {1'b0, total_reg}) ? rem_sub[POS_W-1:0]
                                                         : rem_shift[POS_W-1:0];
    assign last_frame = FRAME_W'(frames_used - CNT_W'(1));

    assign status.total_zero = (frames_used == '0) || (total_reg == '0);
    assign status.pos_ge     = (pos_reg >= total_reg);
    assign status.hit        = cmd.search_step && rd_valid_reg && ({1'b0, pos_reg} < cum_sum);

    always_comb
    begin
        total_next   = total_reg;
        pos_next     = pos_reg;
        playing_next = playing_reg;
        shown_next   = shown_reg;
        if (cmd.load)
        begin
            case (item.command)
                CMD_ADVANCE:
                begin
                    if (playing_reg)
                        pos_next = pos_sum[POS_W] ? '1 : pos_sum[POS_W-1:0];
                end
                CMD_REWIND:
                begin
                    pos_next   = '0;
                    shown_next = '0;
                end
                CMD_PLAY:
                begin
                    playing_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.sum_clr)
            total_next = '0;
        else if (cmd.sum_step && rd_valid_reg)
            total_next = total_reg + POS_W'(rd_data_reg);
        if (cmd.stop)
        begin
            playing_next = 1'b0;
            pos_next     = '0;
        end
        if (cmd.div_last)
            pos_next = rem_new;
        if (cmd.finish)
            shown_next = frame_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg    <= '0;
            pos_reg      <= '0;
            playing_reg  <= 1'b0;
            shown_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            total_reg    <= total_next;
            pos_reg      <= pos_next;
            playing_reg  <= playing_next;
            shown_reg    <= shown_next;
            rd_valid_reg <= cmd.rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            before_reg <= shown_reg;
        if (cmd.walk_clr)
            cum_reg <= '0;
        else if (cmd.search_step && rd_valid_reg)
            cum_reg <= cum_sum[POS_W-1:0];
        if (cmd.div_init)
        begin
            rem_reg <= '0;
            dvd_reg <= pos_reg;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_new;
            dvd_reg <= {dvd_reg[POS_W-2:0], 1'b0};
        end
        if (cmd.zero_frame)
            frame_reg <= '0;
        else if (cmd.stop || cmd.search_fail)
            frame_reg <= last_frame;
        else if (status.hit)
            frame_reg <= rd_idx_reg;
        if (cmd.finish)
        begin
            result_reg.current_frame <= frame_reg;
            result_reg.is_playing    <= playing_reg;
            result_reg.frame_changed <= (frame_reg != before_reg);
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

FILE: rtl/animation_frame_selector.sv
// animation_frame_selector: top level with the configuration registers
// depends on afs_pkg, afs_ctrl and afs_datapath
`timescale 1ns / 1ps
`default_nettype none

// Each item is taken in, its frame delays are re-added, a decision is made, the
// cumulative delays are walked and the result word is loaded; the walk is skipped
// when the total is zero or non-looping playback stops at the end. When looping
// playback passes the end, the bit-serial remainder unit wraps the position
// before the walk. The single read port of the delay memory sets the walk length.
// item_stall holds off a new item until the current one is finished. A finished word
// waits in the output register while the next item is taken in.

module animation_frame_selector
    import afs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_stall,
    input  wire afs_in_t               item,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output afs_out_t                   result,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    logic [FRAME_COUNT_W-1:0] frame_count_reg, frame_count_next;
    logic                     loop_enable_reg, loop_enable_next;
    logic [CNT_W-1:0]         frames_used;
    afs_cmd_t                 cmd;
    afs_stat_t                status;

    assign pready = 1'b1;

    always_comb
    begin
        frame_count_next = frame_count_reg;
        loop_enable_next = loop_enable_reg;
        if (psel && penable && pwrite)
        begin
            case (paddr[2])
                REG_FRAME_COUNT: frame_count_next = pwdata[FRAME_COUNT_W-1:0];
                REG_LOOP_ENABLE: loop_enable_next = pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= '0;
            loop_enable_reg <= 1'b1;
        end
        else
        begin
            frame_count_reg <= frame_count_next;
            loop_enable_reg <= loop_enable_next;
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_FRAME_COUNT: prdata = APB_DATA_W'(frame_count_reg);
            REG_LOOP_ENABLE: prdata = APB_DATA_W'(loop_enable_reg);
            default:         prdata = '0;
        endcase
    end

    // counts above the table depth act as a full table
    assign frames_used = (frame_count_reg > FRAME_COUNT_W'(MAX_FRAMES))
                         ? CNT_W'(MAX_FRAMES) : CNT_W'(frame_count_reg);

    afs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .frames_used  (frames_used),
        .loop_enable  (loop_enable_reg),
        .status       (status),
        .cmd          (cmd)
    );

    afs_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .cmd         (cmd),
        .frames_used (frames_used),
        .status      (status),
        .result      (result)
    );

endmodule

`default_nettype wire
